// ===== sv/bpr_pkg.sv =====
// Shared types, widths, register codes and defaults for the bisection root finder.
package bpr_pkg;

  localparam int DATA_W = 32;
  localparam int ITER_W = 7;
  localparam int DEG_W = 3;
  localparam int TOL_W = 31;
  localparam int REG_W = 3;
  localparam int ADDR_W = REG_W + 2;

  localparam int MAX_ITER_DEF = 64;
  localparam int MAX_DEGREE_DEF = 5;
  localparam int FRAC_BITS_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // register map, byte address = 4 * code
  localparam logic [REG_W-1:0] REG_DEGREE = 3'd0;
  localparam logic [REG_W-1:0] REG_COEF_0 = 3'd1;
  localparam logic [REG_W-1:0] REG_COEF_1 = 3'd2;
  localparam logic [REG_W-1:0] REG_COEF_2 = 3'd3;
  localparam logic [REG_W-1:0] REG_COEF_3 = 3'd4;
  localparam logic [REG_W-1:0] REG_COEF_4 = 3'd5;
  localparam logic [REG_W-1:0] REG_COEF_5 = 3'd6;
  localparam logic [REG_W-1:0] REG_TOL = 3'd7;

  // status from the Horner unit to the sequencer
  typedef struct packed {
    logic done;
    logic sat;
  } hrn_stat_t;

endpackage

// ===== sv/bpr_if.sv =====
// Request and result channel interfaces for the bisection root finder.
interface bpr_req_if;
  import bpr_pkg::*;
  logic  valid;
  logic  ready;
  data_t end_a;
  data_t end_b;
  modport source (output valid, end_a, end_b, input ready);
  modport sink (input valid, end_a, end_b, output ready);
endinterface

interface bpr_res_if;
  import bpr_pkg::*;
  logic              valid;
  logic              ready;
  data_t             root;
  logic [ITER_W-1:0] iterations;
  logic              hit_limit;
  logic              overflowed;
  modport source (output valid, root, iterations, hit_limit, overflowed, input ready);
  modport sink (input valid, root, iterations, hit_limit, overflowed, output ready);
endinterface

// ===== sv/bpr_horner.sv =====
// Horner evaluator on one shared multiplier: a multiply phase, then a shift, add and saturate phase per coefficient.
module bpr_horner #(
  parameter int MAX_DEGREE = bpr_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS = bpr_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  bpr_pkg::data_t            x,
  input  logic [bpr_pkg::DEG_W-1:0] degree,
  input  bpr_pkg::data_t            coef [MAX_DEGREE+1],
  output bpr_pkg::data_t            value,
  output bpr_pkg::hrn_stat_t        stat
);
  import bpr_pkg::*;

  localparam int KW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int PW = 2 * DATA_W;
  localparam int SW = PW - FRAC_BITS + 1;

  logic                 busy;
  logic                 phase;     // 0: multiply, 1: shift, add, saturate
  logic [KW-1:0]        idx;
  data_t                acc;
  data_t                xr;
  logic signed [PW-1:0] prod;
  logic                 done;
  logic                 sat;

  logic [KW-1:0]        deg_c;
  logic signed [PW-1:0] mul;
  logic signed [PW-1:0] shifted;
  logic signed [SW-1:0] sum;
  data_t                cf;
  logic                 ovf;

  always_comb begin
    if (degree > DEG_W'(MAX_DEGREE)) begin
      deg_c = KW'(MAX_DEGREE);
    end else begin
      deg_c = KW'(degree);
    end
    mul = acc * xr;
    shifted = prod >>> FRAC_BITS;
    cf = coef[idx];
    sum = $signed({shifted[SW-2], shifted[SW-2:0]}) +
          $signed({{(SW-DATA_W){cf[DATA_W-1]}}, cf});
    ovf = !((&sum[SW-1:DATA_W-1]) || !(|sum[SW-1:DATA_W-1]));
  end

  // acc starts at zero so the first step just loads the top coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        sat   <= 1'b0;
        idx   <= deg_c;
        acc   <= '0;
        xr    <= x;
      end else if (busy) begin
        if (!phase) begin
          prod  <= mul;
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          if (ovf) begin
            sat <= 1'b1;
            acc <= sum[SW-1] ? DATA_MIN : DATA_MAX;
          end else begin
            acc <= sum[DATA_W-1:0];
          end
          if (idx == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end
    end
  end

  assign value = acc;
  assign stat.done = done;
  assign stat.sat = sat;

endmodule

// ===== sv/bisection_poly_root.sv =====
// Bisection root finder for a configured polynomial in signed fixed point.
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  end_a, end_b
//  res      out  res.valid/res.ready  root, iterations, hit_limit, overflowed
//  apb      in   psel/penable/pwrite  paddr, pwdata -> prdata, pready = 1
//
// One item at a time in the sequencer; req.ready is high only when it is idle.
// A bisection step runs two Horner passes on the shared multiplier, each of
// d+1 multiply-adds, d the clamped degree. At most MAX_ITER steps are run
// per item; the result is offered in the cycle the block is ready again.
// A finished item moves to an output register, so the next item may start
// while that result waits; a later finish holds in S_OUT until it is taken.
// Synchronous reset returns to idle and loads the register reset values.
module bisection_poly_root #(
  parameter int MAX_ITER = bpr_pkg::MAX_ITER_DEF,
  parameter int MAX_DEGREE = bpr_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS = bpr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bpr_req_if.sink                    req,
  bpr_res_if.source                  res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpr_pkg::ADDR_W-1:0] paddr,
  input  logic [bpr_pkg::DATA_W-1:0] pwdata,
  output logic [bpr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import bpr_pkg::*;

  localparam int CW = $clog2(MAX_ITER + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MID  = 3'd1;  // form midpoint, start f(c)
  localparam logic [2:0] S_WC   = 3'd2;  // wait f(c), then start f(b)
  localparam logic [2:0] S_WB   = 3'd3;  // wait f(b), move one end
  localparam logic [2:0] S_CHK  = 3'd4;  // width and cap test
  localparam logic [2:0] S_OUT  = 3'd5;  // hand result to output register

  // configuration registers
  logic [DEG_W-1:0] degree;
  data_t            coef [MAX_DEGREE+1];
  logic [TOL_W-1:0] tolerance;

  // working state
  logic [2:0]    state;
  data_t         lo_end;
  data_t         hi_end;
  data_t         mid;
  logic [CW-1:0] step_count;
  logic          sat_seen;
  logic          fc_pos;
  logic          fc_neg;
  logic          hit_limit;

  // output register
  logic              out_valid;
  data_t             out_root;
  logic [ITER_W-1:0] out_iter;
  logic              out_hit;
  logic              out_ovf;
  logic              out_load;

  logic              cfg_wr;
  logic [REG_W-1:0]  reg_idx;
  logic signed [DATA_W:0] mid_sum;
  data_t             mid_c;
  logic signed [DATA_W:0] diff;
  logic signed [DATA_W:0] tol_x;
  logic              met;
  logic              h_start;
  data_t             h_x;
  data_t             f_val;
  hrn_stat_t         h_stat;
  logic              same_sign;

  // ---------------------------------------------------------------
  // APB register file; writes land on the access cycle
  // ---------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      degree    <= '0;
      tolerance <= TOL_RESET;
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_wr) begin
      if (reg_idx == REG_DEGREE) begin
        degree <= pwdata[DEG_W-1:0];
      end
      if (reg_idx == REG_TOL) begin
        tolerance <= pwdata[TOL_W-1:0];
      end
      // coefficients above MAX_DEGREE are never used, so not stored
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (reg_idx == REG_W'(int'(REG_COEF_0) + k)) begin
          coef[k] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DEGREE: prdata = DATA_W'(degree);
      REG_TOL:    prdata = DATA_W'(tolerance);
      default: begin
        for (int k = 0; k <= MAX_DEGREE; k++) begin
          if (reg_idx == REG_W'(int'(REG_COEF_0) + k)) begin
            prdata = coef[k];
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------
  // midpoint: exact 33-bit sum, arithmetic shift floors
  assign mid_sum = {lo_end[DATA_W-1], lo_end} + {hi_end[DATA_W-1], hi_end};
  assign mid_c   = mid_sum[DATA_W:1];

  // |a - b| <= tol checked as -tol <= a - b <= tol
  assign diff  = {lo_end[DATA_W-1], lo_end} - {hi_end[DATA_W-1], hi_end};
  assign tol_x = $signed({2'b00, tolerance});
  assign met   = (diff <= tol_x) && (diff >= -tol_x);

  // f(c)*f(b) > 0 from signs only
  assign same_sign = (fc_pos && !f_val[DATA_W-1] && (f_val != '0)) ||
                     (fc_neg && f_val[DATA_W-1]);

  assign h_start = (state == S_MID) || ((state == S_WC) && h_stat.done);
  assign h_x     = (state == S_MID) ? mid_c : hi_end;

  bpr_horner #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_horner (
    .clk    (clk),
    .rst    (rst),
    .start  (h_start),
    .x      (h_x),
    .degree (degree),
    .coef   (coef),
    .value  (f_val),
    .stat   (h_stat)
  );

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  // a finished item moves on once the output register is empty or emptying
  assign out_load = (state == S_OUT) && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            lo_end     <= req.end_a;
            hi_end     <= req.end_b;
            step_count <= '0;
            sat_seen   <= 1'b0;
            state      <= S_MID;
          end
        end
        S_MID: begin
          mid   <= mid_c;
          state <= S_WC;
        end
        S_WC: begin
          if (h_stat.done) begin
            fc_pos   <= !f_val[DATA_W-1] && (f_val != '0);
            fc_neg   <= f_val[DATA_W-1];
            sat_seen <= sat_seen | h_stat.sat;
            state    <= S_WB;
          end
        end
        S_WB: begin
          if (h_stat.done) begin
            sat_seen <= sat_seen | h_stat.sat;
            if (same_sign) begin
              hi_end <= mid;
            end else begin
              lo_end <= mid;
            end
            step_count <= step_count + 1'b1;
            state      <= S_CHK;
          end
        end
        S_CHK: begin
          if (met || (step_count == CW'(MAX_ITER))) begin
            hit_limit <= !met;
            state     <= S_OUT;
          end else begin
            state <= S_MID;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: loaded from the finished item, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_root  <= lo_end;
        out_iter  <= ITER_W'(step_count);
        out_hit   <= hit_limit;
        out_ovf   <= sat_seen;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign res.valid      = out_valid;
  assign res.root       = out_root;
  assign res.iterations = out_iter;
  assign res.hit_limit  = out_hit;
  assign res.overflowed = out_ovf;

endmodule

// ===== sv/bpr_checker.sv =====
// Port-level checks for the bisection root finder, bound to the top level.
module bpr_checker #(
  parameter int MAX_ITER = bpr_pkg::MAX_ITER_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input bpr_pkg::data_t             res_root,
  input logic [bpr_pkg::ITER_W-1:0] res_iterations,
  input logic                       res_hit_limit
);
  import bpr_pkg::*;

  // a stalled result keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_root) &&
      $stable(res_iterations) && $stable(res_hit_limit))
    else $error("result changed while stalled");

  // one item in the sequencer: intake closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("no work cycles after accept");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_iterations >= ITER_W'(1)) &&
      (res_iterations <= ITER_W'(MAX_ITER)))
    else $error("step count out of range");

  a_limit_flag: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_iterations != ITER_W'(MAX_ITER)) |-> !res_hit_limit)
    else $error("cap flag without reaching the cap");

endmodule

bind bisection_poly_root bpr_checker #(.MAX_ITER(MAX_ITER)) u_bpr_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_root       (res.root),
  .res_iterations (res.iterations),
  .res_hit_limit  (res.hit_limit)
);
